@@ sv/xcr_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// xcr_pkg: shared definitions for the XMODEM-CRC receiver
// Widths, protocol characters, command and status codes, the queued word
// type and the CRC-16 byte update.
// ---------------------------------------------------------------------------
package xcr_pkg;

   // Field widths of the request and response words.
   localparam int CMD_W     = 2;
   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = CMD_W;
   localparam int RSP_BITS  = BYTE_W + ADDR_W + BYTE_W + STATUS_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 2;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int TICK_W     = 32;
   localparam int RETRY_W    = 4;

   // Packet geometry.
   localparam int DATA_BYTES = 128;
   localparam int IDX_W      = $clog2(DATA_BYTES + 1);
   localparam int CRC_W      = 16;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   // Queue between front and engine (depth is a power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Reset values of the configuration registers.
   localparam logic [ADDR_W-1:0]  TARGET_BASE_RST   = '0;
   localparam logic [TICK_W-1:0]  READ_TIMEOUT_RST  = 32'd3000;
   localparam logic [TICK_W-1:0]  START_TIMEOUT_RST = 32'd3000;
   localparam logic [RETRY_W-1:0] MAX_RETRIES_RST   = 4'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_READ_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_TIMEOUT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RETRIES   = 2'd3;

   // Command codes on req_tuser.
   localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   // Protocol characters.
   localparam logic [BYTE_W-1:0] CH_SOH   = 8'h01;
   localparam logic [BYTE_W-1:0] CH_EOT   = 8'h04;
   localparam logic [BYTE_W-1:0] CH_ACK   = 8'h06;
   localparam logic [BYTE_W-1:0] CH_NAK   = 8'h15;
   localparam logic [BYTE_W-1:0] CH_START = 8'h43;
   localparam logic [BYTE_W-1:0] CMPL_OK  = 8'hFF;

   // End codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_BUSY    = 3'd0,
      ST_OK      = 3'd1,
      ST_NOTHING = 3'd2,
      ST_HEADER  = 3'd3,
      ST_NUMBER  = 3'd4,
      ST_DUP     = 3'd5,
      ST_CRC     = 3'd6
   } status_type;

   // Kind of a queued word, decided by the front.
   typedef enum logic [1:0] {
      KIND_BEGIN = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
   } item_type;

   // Receiver phases.
   typedef enum logic [7:0] {
      PH_IDLE  = 8'b0000_0001,
      PH_START = 8'b0000_0010,
      PH_HEAD  = 8'b0000_0100,
      PH_NUM   = 8'b0000_1000,
      PH_CMPL  = 8'b0001_0000,
      PH_DATA  = 8'b0010_0000,
      PH_CRCH  = 8'b0100_0000,
      PH_CRCL  = 8'b1000_0000
   } phase_type;

   // CRC-16 update with one data byte, MSB first.
   function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ sv/xmodem_crc_receiver.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// xmodem_crc_receiver: XMODEM-CRC receiver
// Front intake with a two-word queue feeding the protocol engine.
// ---------------------------------------------------------------------------
// Every request word (begin, received byte, timer tick or unused command)
// yields exactly one response word. The block sustains one word per clock
// cycle while the response side is not stalled; a request word is held in
// the two-entry intake queue and then in the response register, and the
// engine updates the CRC and all packet checks for one byte ahead of the
// response register. A stalled response side fills the queue and then drops
// req_tready. Data bytes leave as write words on the response side; there is
// no memory or clearing pass inside. Configuration must be written while the
// receiver is idle; the block itself does not enforce this.
module xmodem_crc_receiver (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [xcr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [xcr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [xcr_pkg::REQ_TDATA_W-1:0]  req_tdata,   // rx_byte
   input  logic [xcr_pkg::REQ_TUSER_W-1:0]  req_tuser,   // cmd
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [xcr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // tx_byte, wr_addr, wr_data, status
   output logic [xcr_pkg::RSP_TUSER_W-1:0]  rsp_tuser,   // tx_valid, wr_valid
   output logic                             rsp_tlast    // done_res
);
   import xcr_pkg::*;

   logic     head_valid;
   item_type head_item;
   logic     head_pop;

   // Intake and queue.
   xcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   // Protocol engine.
   xcr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ sv/xcr_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// xcr_front: request intake
// Classifies each request word by its command and holds it in a short
// queue until the engine takes it.
// ---------------------------------------------------------------------------
module xcr_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [xcr_pkg::REQ_TDATA_W-1:0]  req_tdata,   // rx_byte
   input  logic [xcr_pkg::REQ_TUSER_W-1:0]  req_tuser,   // cmd
   output logic                             head_valid,
   output xcr_pkg::item_type                head_item,
   input  logic                             head_pop
);
   import xcr_pkg::*;

   item_type          queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   item_type          new_item;
   logic              push;
   logic              pop;

   // Decode the command into the kind of word.
   always_comb begin
      new_item.data = req_tdata;
      unique case (req_tuser)
         CMD_BEGIN: new_item.kind = KIND_BEGIN;
         CMD_BYTE:  new_item.kind = KIND_BYTE;
         CMD_TICK:  new_item.kind = KIND_TICK;
         default:   new_item.kind = KIND_NONE;
      endcase
   end

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_valid = (count_ff != '0);
   assign pop        = head_pop && head_valid;
   assign head_item  = queue_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

@@ sv/xcr_engine.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// xcr_engine: protocol engine
// Holds the configuration registers, runs the XMODEM-CRC receive state machine
// one queued word per cycle unless the response side stalls, and drives the response register.
// ---------------------------------------------------------------------------
module xcr_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [xcr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [xcr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             head_valid,
   input  xcr_pkg::item_type                head_item,
   output logic                             head_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [xcr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // tx_byte, wr_addr, wr_data, status
   output logic [xcr_pkg::RSP_TUSER_W-1:0]  rsp_tuser,   // tx_valid, wr_valid
   output logic                             rsp_tlast    // done_res
);
   import xcr_pkg::*;

   // Configuration registers.
   logic [ADDR_W-1:0]  target_base_ff;
   logic [TICK_W-1:0]  read_timeout_ff;
   logic [TICK_W-1:0]  start_timeout_ff;
   logic [RETRY_W-1:0] max_retries_ff;

   // Receiver state.
   phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]   byte_index_ff, byte_index_in;
   logic [BYTE_W-1:0]  expected_ff, expected_in;
   logic [BYTE_W-1:0]  rx_num_ff, rx_num_in;
   logic [BYTE_W-1:0]  rx_cmpl_ff, rx_cmpl_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [BYTE_W-1:0]  crc_msb_ff, crc_msb_in;
   logic               first_ack_ff, first_ack_in;
   logic [RETRY_W-1:0] retries_ff, retries_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [ADDR_W-1:0]  wptr_ff, wptr_in;
   logic [ADDR_W-1:0]  pstart_ff, pstart_in;

   // Response register.
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TUSER_W-1:0] rsp_user_ff;
   logic                   rsp_last_ff;

   // Result of the current word.
   logic               res_tx_valid;
   logic [BYTE_W-1:0]  res_tx_byte;
   logic               res_wr_valid;
   logic [ADDR_W-1:0]  res_wr_addr;
   logic [BYTE_W-1:0]  res_wr_data;
   logic               res_done;
   status_type         res_status;

   logic               take;
   logic               fin;
   status_type         fin_code;
   logic [RETRY_W-1:0] retry_load;
   logic [TICK_W-1:0]  tick_sat;
   logic [CRC_W-1:0]   got_crc;

   assign take       = head_valid && (!rsp_valid_ff || rsp_tready);
   assign head_pop   = take;
   assign retry_load = (max_retries_ff == '0) ? RETRY_W'(1) : max_retries_ff;
   assign tick_sat   = (tick_ff == '1) ? tick_ff : tick_ff + 1'b1;
   assign got_crc    = {crc_msb_ff, head_item.data};

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_base_ff   <= TARGET_BASE_RST;
         read_timeout_ff  <= READ_TIMEOUT_RST;
         start_timeout_ff <= START_TIMEOUT_RST;
         max_retries_ff   <= MAX_RETRIES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_BASE:   target_base_ff   <= csr_wdata[ADDR_W-1:0];
            REG_READ_TIMEOUT:  read_timeout_ff  <= csr_wdata[TICK_W-1:0];
            REG_START_TIMEOUT: start_timeout_ff <= csr_wdata[TICK_W-1:0];
            REG_MAX_RETRIES:   max_retries_ff   <= csr_wdata[RETRY_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state and result of the word at the queue head.
   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      expected_in   = expected_ff;
      rx_num_in     = rx_num_ff;
      rx_cmpl_in    = rx_cmpl_ff;
      crc_in        = crc_ff;
      crc_msb_in    = crc_msb_ff;
      first_ack_in  = first_ack_ff;
      retries_in    = retries_ff;
      tick_in       = tick_ff;
      wptr_in       = wptr_ff;
      pstart_in     = pstart_ff;
      res_tx_valid  = 1'b0;
      res_tx_byte   = '0;
      res_wr_valid  = 1'b0;
      res_wr_addr   = '0;
      res_wr_data   = '0;
      res_done      = 1'b0;
      res_status    = ST_BUSY;
      fin           = 1'b0;
      fin_code      = ST_BUSY;

      unique case (head_item.kind)
         KIND_BEGIN: begin
            phase_in      = PH_START;
            expected_in   = BYTE_W'(1);
            first_ack_in  = 1'b0;
            tick_in       = '0;
            byte_index_in = '0;
            retries_in    = retry_load;
            wptr_in       = target_base_ff;
            pstart_in     = target_base_ff;
            res_tx_valid  = 1'b1;
            res_tx_byte   = CH_START;
         end
         KIND_BYTE: begin
            if (phase_ff != PH_IDLE) begin
               tick_in = '0;
               unique case (phase_ff) inside
                  PH_START, PH_HEAD: begin
                     // A byte during the start wait is the first header byte.
                     if (phase_ff == PH_START) begin
                        retries_in = retry_load;
                     end
                     if (head_item.data == CH_SOH) begin
                        phase_in = PH_NUM;
                     end else if (head_item.data == CH_EOT) begin
                        res_tx_valid = 1'b1;
                        res_tx_byte  = CH_ACK;
                        phase_in     = PH_IDLE;
                        res_done     = 1'b1;
                        res_status   = ST_OK;
                     end else begin
                        fin      = 1'b1;
                        fin_code = ST_HEADER;
                     end
                  end
                  PH_NUM: begin
                     rx_num_in = head_item.data;
                     phase_in  = PH_CMPL;
                  end
                  PH_CMPL: begin
                     rx_cmpl_in    = head_item.data;
                     crc_in        = '0;
                     byte_index_in = '0;
                     phase_in      = PH_DATA;
                  end
                  PH_DATA: begin
                     res_wr_valid  = 1'b1;
                     res_wr_addr   = wptr_ff;
                     res_wr_data   = head_item.data;
                     wptr_in       = wptr_ff + 1'b1;
                     crc_in        = crc_step(crc_ff, head_item.data);
                     byte_index_in = byte_index_ff + 1'b1;
                     if (byte_index_in >= IDX_W'(DATA_BYTES)) begin
                        phase_in = PH_CRCH;
                     end
                  end
                  PH_CRCH: begin
                     crc_msb_in = head_item.data;
                     phase_in   = PH_CRCL;
                  end
                  PH_CRCL: begin
                     // Checks in order: complement, duplicate, number, CRC.
                     fin = 1'b1;
                     if ((rx_num_ff ^ rx_cmpl_ff) != CMPL_OK) begin
                        fin_code = ST_NUMBER;
                     end else if (rx_num_ff == expected_ff - 1'b1) begin
                        fin_code = ST_DUP;
                     end else if (rx_num_ff != expected_ff) begin
                        fin_code = ST_NUMBER;
                     end else if (got_crc != crc_ff) begin
                        fin_code = ST_CRC;
                     end else begin
                        fin_code = ST_OK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         KIND_TICK: begin
            if (phase_ff != PH_IDLE) begin
               tick_in = tick_sat;
               if (phase_ff == PH_START) begin
                  if (tick_sat >= start_timeout_ff) begin
                     res_tx_valid = 1'b1;
                     res_tx_byte  = CH_START;
                     tick_in      = '0;
                  end
               end else if (tick_sat >= read_timeout_ff) begin
                  fin      = 1'b1;
                  fin_code = ST_NOTHING;
               end
            end
         end
         default: ;
      endcase

      // End of a packet attempt, good or bad.
      if (fin) begin
         tick_in       = '0;
         byte_index_in = '0;
         phase_in      = PH_HEAD;
         if (fin_code == ST_OK) begin
            res_tx_valid = 1'b1;
            res_tx_byte  = CH_ACK;
            first_ack_in = 1'b1;
            expected_in  = expected_ff + 1'b1;
            retries_in   = retry_load;
            pstart_in    = wptr_ff;
         end else begin
            if (fin_code == ST_DUP) begin
               res_tx_valid = 1'b1;
               res_tx_byte  = CH_ACK;
            end else if (first_ack_ff) begin
               res_tx_valid = 1'b1;
               res_tx_byte  = CH_NAK;
            end
            // Rewind to the start of the failed packet.
            wptr_in = pstart_ff;
            if (retries_in <= RETRY_W'(1)) begin
               retries_in = '0;
               phase_in   = PH_IDLE;
               res_done   = 1'b1;
               res_status = fin_code;
            end else begin
               retries_in = retries_in - 1'b1;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_index_ff <= '0;
         expected_ff   <= BYTE_W'(1);
         rx_num_ff     <= '0;
         rx_cmpl_ff    <= '0;
         crc_ff        <= '0;
         crc_msb_ff    <= '0;
         first_ack_ff  <= 1'b0;
         retries_ff    <= '0;
         tick_ff       <= '0;
         wptr_ff       <= '0;
         pstart_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            phase_ff      <= phase_in;
            byte_index_ff <= byte_index_in;
            expected_ff   <= expected_in;
            rx_num_ff     <= rx_num_in;
            rx_cmpl_ff    <= rx_cmpl_in;
            crc_ff        <= crc_in;
            crc_msb_ff    <= crc_msb_in;
            first_ack_ff  <= first_ack_in;
            retries_ff    <= retries_in;
            tick_ff       <= tick_in;
            wptr_ff       <= wptr_in;
            pstart_ff     <= pstart_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= RSP_TDATA_W'({res_status, res_wr_data, res_wr_addr, res_tx_byte});
         rsp_user_ff <= {res_wr_valid, res_tx_valid};
         rsp_last_ff <= res_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

@@ sv/xcr_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// xcr_checker: port checks for the XMODEM-CRC receiver
// Watches the response port for consistent words and bound to the top level.
// ---------------------------------------------------------------------------
module xcr_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [xcr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic [xcr_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  logic                             rsp_tlast
);
   import xcr_pkg::*;

   logic [BYTE_W-1:0]   tx_byte;
   logic [STATUS_W-1:0] status;

   assign tx_byte = rsp_tdata[BYTE_W-1:0];
   assign status  = rsp_tdata[RSP_BITS-1 -: STATUS_W];

   // A finished transfer carries an end code, and only then.
   a_done_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (status != ST_BUSY)))
      else $error("done flag and status disagree");

   // A data write never comes with a control character or the end.
   a_write_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && !rsp_tlast)
      else $error("data write mixed with control output");

   // Sent characters are C, ACK or NAK; nothing is sent as zero.
   a_tx_char: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] ? (tx_byte == CH_START || tx_byte == CH_ACK ||
                                       tx_byte == CH_NAK) : (tx_byte == '0)))
      else $error("illegal control character");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response word changed");

endmodule

bind xmodem_crc_receiver xcr_checker u_checker (.*);
`default_nettype wire

@@ tb/xcr_tb_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcr_tb_pkg: verification helpers for the XMODEM-CRC receiver
// Holds the bit-serial CRC-16 used both to build packets and to predict
// the receiver's packet checks.
// ---------------------------------------------------------------------------
package xcr_tb_pkg;

   localparam logic [15:0] CRC16_POLY = 16'h1021;

   // Shift one byte through the CRC register one bit at a time, MSB first.
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] acc;
      int          bit_n;
      acc = crc;
      for (bit_n = 7; bit_n >= 0; bit_n--) begin
         if (acc[15] ^ data[bit_n]) begin
            acc = {acc[14:0], 1'b0} ^ CRC16_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

@@ tb/xmodem_crc_receiver_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xmodem_crc_receiver_checker: response checker for the XMODEM-CRC receiver
// Watches the configuration port and both stream channels. Every accepted
// request word is run through a cycle-free model of the receiver, and the
// predicted response is queued; every accepted response word is compared
// field by field against the oldest queued prediction.
// ---------------------------------------------------------------------------
module xmodem_crc_receiver_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [xcr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [xcr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [xcr_pkg::REQ_TDATA_W-1:0]  req_tdata,   // rx_byte
   input  logic [xcr_pkg::REQ_TUSER_W-1:0]  req_tuser,   // cmd
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [xcr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // tx_byte, wr_addr, wr_data, status
   input  logic [xcr_pkg::RSP_TUSER_W-1:0]  rsp_tuser,   // tx_valid, wr_valid
   input  logic                             rsp_tlast,   // done_res
   output int                               error_count,
   output int                               outstanding
);
   import xcr_pkg::*;
   import xcr_tb_pkg::*;

   // Bit positions of the response fields.
   localparam int ADDR_LSB   = BYTE_W;
   localparam int DATA_LSB   = ADDR_LSB + ADDR_W;
   localparam int STATUS_LSB = DATA_LSB + BYTE_W;
   localparam int PAD_LSB    = STATUS_LSB + STATUS_W;
   localparam int TXV_BIT    = 0;
   localparam int WRV_BIT    = 1;

   typedef struct packed {
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              wr_valid;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              done;
      status_type        status;
   } reply_type;

   reply_type expected_replies[$];
   reply_type next_reply;
   int        mismatches = 0;
   int        pending    = 0;

   // Configuration copy.
   logic [ADDR_W-1:0]  cfg_base;
   logic [TICK_W-1:0]  cfg_read_to;
   logic [TICK_W-1:0]  cfg_start_to;
   logic [RETRY_W-1:0] cfg_retries;

   // Receiver state copy.
   phase_type          rx_phase;
   logic [IDX_W-1:0]   data_count;
   logic [BYTE_W-1:0]  expected_number;
   logic [BYTE_W-1:0]  rcv_number;
   logic [BYTE_W-1:0]  rcv_complement;
   logic [15:0]        crc_acc;
   logic [BYTE_W-1:0]  crc_msb;
   logic               acked;
   logic [RETRY_W-1:0] retries;
   logic [TICK_W-1:0]  ticks;
   logic [ADDR_W-1:0]  wr_ptr;
   logic [ADDR_W-1:0]  pkt_ptr;

   assign error_count = mismatches;
   assign outstanding = pending;

   // A retry limit of zero behaves as one.
   function automatic logic [RETRY_W-1:0] retry_budget();
      return (cfg_retries == '0) ? 4'd1 : cfg_retries;
   endfunction

   task automatic send_char(input logic [BYTE_W-1:0] c);
      next_reply.tx_valid = 1'b1;
      next_reply.tx_byte  = c;
   endtask

   // Close one packet attempt, successful or not.
   task automatic end_attempt(input status_type code);
      ticks      = '0;
      data_count = '0;
      rx_phase   = PH_HEAD;
      if (code == ST_OK) begin
         send_char(CH_ACK);
         acked           = 1'b1;
         expected_number = expected_number + 8'd1;
         retries         = retry_budget();
         pkt_ptr         = wr_ptr;
      end else begin
         if (code == ST_DUP) begin
            send_char(CH_ACK);
         end else if (acked) begin
            send_char(CH_NAK);
         end
         // A failed attempt rewinds to the start of the packet.
         wr_ptr = pkt_ptr;
         if (retries <= 4'd1) begin
            retries           = '0;
            rx_phase          = PH_IDLE;
            next_reply.done   = 1'b1;
            next_reply.status = code;
         end else begin
            retries = retries - 4'd1;
         end
      end
   endtask

   task automatic take_rx_byte(input logic [BYTE_W-1:0] b);
      logic [15:0]       got_crc;
      logic [BYTE_W-1:0] prev_number;
      ticks = '0;
      // The first byte after the start wait is parsed as a header.
      if (rx_phase == PH_START) begin
         retries  = retry_budget();
         rx_phase = PH_HEAD;
      end
      case (rx_phase)
         PH_HEAD: begin
            if (b == CH_SOH) begin
               rx_phase = PH_NUM;
            end else if (b == CH_EOT) begin
               send_char(CH_ACK);
               rx_phase          = PH_IDLE;
               next_reply.done   = 1'b1;
               next_reply.status = ST_OK;
            end else begin
               end_attempt(ST_HEADER);
            end
         end
         PH_NUM: begin
            rcv_number = b;
            rx_phase   = PH_CMPL;
         end
         PH_CMPL: begin
            rcv_complement = b;
            crc_acc        = '0;
            data_count     = '0;
            rx_phase       = PH_DATA;
         end
         PH_DATA: begin
            next_reply.wr_valid = 1'b1;
            next_reply.wr_addr  = wr_ptr;
            next_reply.wr_data  = b;
            wr_ptr              = wr_ptr + 1'b1;
            crc_acc             = crc16_update(crc_acc, b);
            data_count          = data_count + 1'b1;
            if (data_count >= IDX_W'(DATA_BYTES)) begin
               rx_phase = PH_CRCH;
            end
         end
         PH_CRCH: begin
            crc_msb  = b;
            rx_phase = PH_CRCL;
         end
         PH_CRCL: begin
            got_crc     = {crc_msb, b};
            prev_number = expected_number - 8'd1;
            if ((rcv_number ^ rcv_complement) != CMPL_OK) begin
               end_attempt(ST_NUMBER);
            end else if (rcv_number == prev_number) begin
               end_attempt(ST_DUP);
            end else if (rcv_number != expected_number) begin
               end_attempt(ST_NUMBER);
            end else if (got_crc != crc_acc) begin
               end_attempt(ST_CRC);
            end else begin
               end_attempt(ST_OK);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic take_tick();
      if (ticks != '1) begin
         ticks = ticks + 1'b1;
      end
      if (rx_phase == PH_START) begin
         if (ticks >= cfg_start_to) begin
            send_char(CH_START);
            ticks = '0;
         end
      end else if (ticks >= cfg_read_to) begin
         end_attempt(ST_NOTHING);
      end
   endtask

   // Work out the response to one request word and queue it.
   task automatic predict_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
      next_reply = '0;
      case (cmd)
         CMD_BEGIN: begin
            rx_phase        = PH_START;
            expected_number = 8'd1;
            acked           = 1'b0;
            ticks           = '0;
            data_count      = '0;
            retries         = retry_budget();
            wr_ptr          = cfg_base;
            pkt_ptr         = cfg_base;
            send_char(CH_START);
         end
         CMD_BYTE: begin
            if (rx_phase != PH_IDLE) begin
               take_rx_byte(b);
            end
         end
         CMD_TICK: begin
            if (rx_phase != PH_IDLE) begin
               take_tick();
            end
         end
         default: begin
         end
      endcase
      expected_replies.push_back(next_reply);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Sample both channels and the register port at each rising edge.
   always @(posedge clock) begin : track
      reply_type want;
      if (reset) begin
         cfg_base        = 32'd0;
         cfg_read_to     = 32'd3000;
         cfg_start_to    = 32'd3000;
         cfg_retries     = 4'd4;
         rx_phase        = PH_IDLE;
         data_count      = '0;
         expected_number = 8'd1;
         rcv_number      = '0;
         rcv_complement  = '0;
         crc_acc         = '0;
         crc_msb         = '0;
         acked           = 1'b0;
         retries         = '0;
         ticks           = '0;
         wr_ptr          = '0;
         pkt_ptr         = '0;
         expected_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               mismatches++;
               $display("%0t: response word with nothing expected, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = expected_replies.pop_front();
               compare_field("tx_valid", 32'(want.tx_valid), 32'(rsp_tuser[TXV_BIT]));
               compare_field("tx_byte", 32'(want.tx_byte), 32'(rsp_tdata[ADDR_LSB-1:0]));
               compare_field("wr_valid", 32'(want.wr_valid), 32'(rsp_tuser[WRV_BIT]));
               compare_field("wr_addr", want.wr_addr, rsp_tdata[DATA_LSB-1:ADDR_LSB]);
               compare_field("wr_data", 32'(want.wr_data),
                             32'(rsp_tdata[STATUS_LSB-1:DATA_LSB]));
               compare_field("done", 32'(want.done), 32'(rsp_tlast));
               compare_field("status", 32'(want.status),
                             32'(rsp_tdata[PAD_LSB-1:STATUS_LSB]));
               compare_field("tdata padding", 32'd0, 32'(rsp_tdata >> PAD_LSB));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_word(req_tuser, req_tdata);
         end
         if (csr_we) begin
            case (csr_index)
               REG_TARGET_BASE:   cfg_base     = csr_wdata;
               REG_READ_TIMEOUT:  cfg_read_to  = csr_wdata;
               REG_START_TIMEOUT: cfg_start_to = csr_wdata;
               REG_MAX_RETRIES:   cfg_retries  = csr_wdata[RETRY_W-1:0];
               default: begin
               end
            endcase
         end
      end
      pending = expected_replies.size();
   end

endmodule

@@ tb/xmodem_crc_receiver_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xmodem_crc_receiver_test: top level of the XMODEM-CRC receiver testbench
// Drives begin commands, received bytes and timer ticks under several
// register settings: a short directed opening, then transfers built from
// intact packets, duplicates, corrupted headers, numbers and CRCs, stalled
// packets that time out, and noise. The checker compares every response.
// ---------------------------------------------------------------------------
module xmodem_crc_receiver_test;
   import xcr_pkg::*;
   import xcr_tb_pkg::*;

   localparam int CLOCK_PERIOD     = 20;
   localparam int RUN_LIMIT_CYCLES = 400000;
   localparam int ITEM_TARGET      = 2020;
   localparam int HOLD_CYCLES      = 200;
   localparam int TRUNC_MAX_TICKS  = 24;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum int {
      RX_STEADY,
      RX_MOSTLY,
      RX_SPARSE,
      RX_PERIODIC
   } stall_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // rx_byte
   logic [REQ_TUSER_W-1:0] req_tuser;   // cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // tx_byte, wr_addr, wr_data, status
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // tx_valid, wr_valid
   logic                   rsp_tlast;   // done_res
   int                     error_count;
   int                     outstanding;

   int          items_sent   = 0;
   int          burst_left   = 0;
   int          transfers    = 0;
   int          packets_good = 0;
   int          hold_asked   = 0;
   int          hold_served  = 0;
   logic [31:0] read_eff;
   int          tick_cap;
   logic [7:0]  next_number;

   xmodem_crc_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   xmodem_crc_receiver_checker reply_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Offer one request word and wait until it is taken. Words go out in
   // bursts of random length separated by random idle gaps.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_word(CMD_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Load all four registers. Upper bits of the retry write are random,
   // since only the low nibble is kept.
   task automatic apply_config(input logic [31:0] base, input logic [31:0] read_to,
                               input logic [31:0] start_to, input logic [3:0] retry_limit);
      write_reg(REG_TARGET_BASE, base);
      write_reg(REG_READ_TIMEOUT, read_to);
      write_reg(REG_START_TIMEOUT, start_to);
      write_reg(REG_MAX_RETRIES, ($urandom & 32'hFFFF_FFF0) | CSR_DATA_W'(retry_limit));
      read_eff = (read_to == 32'd0) ? 32'd1 : read_to;
      tick_cap = (read_eff > 32'd4) ? 3 : int'(read_eff) - 1;
   endtask

   // Drop valid and wait until every response is back.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // Full packet of DATA_BYTES random bytes, with timer ticks now and then
   // that stay below the read timeout.
   task automatic send_packet(input logic [7:0] number, input logic [7:0] complement,
                              input logic corrupt_crc);
      logic [15:0] crc;
      logic [7:0]  d;
      int          k;
      crc = 16'd0;
      send_word(CMD_BYTE, CH_SOH);
      send_word(CMD_BYTE, number);
      send_word(CMD_BYTE, complement);
      for (k = 0; k < DATA_BYTES; k++) begin
         d   = 8'($urandom_range(0, 255));
         crc = crc16_update(crc, d);
         send_word(CMD_BYTE, d);
         if (tick_cap > 0 && $urandom_range(0, 15) == 0) begin
            send_ticks($urandom_range(1, tick_cap));
         end
      end
      if (corrupt_crc) begin
         crc = crc ^ (16'd1 << $urandom_range(0, 15));
      end
      send_word(CMD_BYTE, crc[15:8]);
      send_word(CMD_BYTE, crc[7:0]);
   endtask

   // One transfer: begin, a few ticks of start wait, a mix of packets,
   // and usually an EOT at the end.
   task automatic run_transfer();
      int          sel;
      int          k;
      logic [7:0]  b;
      logic [7:0]  wrong_no;
      logic [1:0]  cmd;
      send_word(CMD_BEGIN, 8'($urandom_range(0, 255)));
      next_number = 8'd1;
      transfers++;
      send_ticks($urandom_range(0, 4));
      repeat ($urandom_range(1, 4)) begin
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            send_packet(next_number, ~next_number, 1'b0);
            next_number = next_number + 8'd1;
            packets_good++;
         end else if (sel < 63) begin
            // Resend of the previous packet.
            send_packet(next_number - 8'd1, ~(next_number - 8'd1), 1'b0);
         end else if (sel < 70) begin
            send_packet(next_number, ~next_number, 1'b1);
         end else if (sel < 76) begin
            send_packet(next_number, ~next_number ^ (8'd1 << $urandom_range(0, 7)), 1'b0);
         end else if (sel < 82) begin
            // Out-of-sequence number, neither expected nor previous.
            wrong_no = next_number + 8'($urandom_range(1, 254));
            send_packet(wrong_no, ~wrong_no, 1'b0);
         end else if (sel < 88 || read_eff > TRUNC_MAX_TICKS) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_SOH || b == CH_EOT);
            send_word(CMD_BYTE, b);
         end else if (sel < 94) begin
            // Packet cut short, then silence until the read timeout.
            send_word(CMD_BYTE, CH_SOH);
            repeat ($urandom_range(0, 12)) send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
            send_ticks(int'(read_eff));
         end else begin
            for (k = $urandom_range(1, 6); k > 0; k--) begin
               cmd = ($urandom_range(0, 19) == 0) ? CMD_BEGIN : CMD_W'($urandom_range(1, 3));
               if (cmd == CMD_BEGIN) begin
                  next_number = 8'd1;
               end
               send_word(cmd, 8'($urandom_range(0, 255)));
            end
         end
      end
      if ($urandom_range(0, 4) != 0) begin
         send_word(CMD_BYTE, CH_EOT);
      end
   endtask

   // Response side: stretches of different stall patterns, plus a long
   // hold-off whenever one is requested.
   initial begin : receiver
      stall_mode_type mode;
      int             span;
      int             k;
      rsp_tready = 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(8, 60);
         for (k = 0; k < span; k++) begin
            @(negedge clock);
            if (hold_asked != hold_served) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_served++;
            end
            case (mode)
               RX_STEADY:   rsp_tready <= 1'b1;
               RX_MOSTLY:   rsp_tready <= ($urandom_range(0, 9) < 7);
               RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= (k % 3 == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #(CLOCK_PERIOD * RUN_LIMIT_CYCLES);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int phase_no;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = REG_TARGET_BASE;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_TICK;
      read_eff   = 32'd3000;
      tick_cap   = 3;
      next_number = 8'd1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: idle words are ignored, the start byte is taken as
      // a header, and four bad headers end the transfer.
      send_word(CMD_BYTE, 8'hFF);
      send_word(CMD_TICK, 8'h00);
      send_word(CMD_UNUSED, 8'hAA);
      send_word(CMD_BEGIN, 8'h00);
      send_word(CMD_TICK, 8'h00);
      send_word(CMD_UNUSED, 8'h55);
      send_word(CMD_BYTE, 8'h00);
      send_word(CMD_BYTE, CH_NAK);
      send_word(CMD_BYTE, CH_START);
      send_word(CMD_BYTE, 8'hFF);
      send_word(CMD_BYTE, CH_SOH);
      settle();

      // Zero timeouts and a zero retry limit behave as one.
      apply_config(32'hFFFF_FFC0, 32'd0, 32'd0, 4'd0);
      send_word(CMD_BEGIN, 8'hFF);
      send_word(CMD_TICK, 8'h00);
      send_word(CMD_TICK, 8'h00);
      send_word(CMD_BYTE, CH_SOH);
      send_word(CMD_TICK, 8'h00);
      send_word(CMD_BEGIN, 8'h00);
      send_word(CMD_BYTE, CH_EOT);
      // Begin while busy restarts the transfer.
      send_word(CMD_BEGIN, 8'h00);
      send_word(CMD_BYTE, CH_SOH);
      send_word(CMD_BEGIN, 8'h00);
      send_word(CMD_BYTE, CH_EOT);
      settle();

      // Random transfers under a rotating set of register settings.
      for (phase_no = 0; items_sent < ITEM_TARGET; phase_no++) begin
         case (phase_no)
            0: apply_config(32'h0000_1000, 32'd5, 32'd3, 4'd3);
            1: apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 4'd15);
            2: apply_config(32'h0000_0000, 32'd1, 32'hFFFF_FFFF, 4'd1);
            default: apply_config($urandom, $urandom_range(2, 12), $urandom_range(1, 6),
                                  4'($urandom_range(1, 15)));
         endcase
         if (phase_no == 0) begin
            hold_asked++;
         end
         repeat (2) run_transfer();
         settle();
      end

      repeat (10) @(negedge clock);
      $display("Run covered %0d request words in %0d transfers over %0d register settings,",
               items_sent, transfers, phase_no + 2);
      $display("with %0d in-sequence packets and the rest duplicates, errors and noise.",
               packets_good);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/xcr_pkg.sv
sv/xcr_front.sv
sv/xcr_engine.sv
sv/xmodem_crc_receiver.sv
sv/xcr_checker.sv
tb/xcr_tb_pkg.sv
tb/xmodem_crc_receiver_checker.sv
tb/xmodem_crc_receiver_test.sv
